>>> rtl/core/bytecode_cpu_core_defines.svh
// Assertion macros shared by the core modules.
// No dependencies.
`ifndef BYTECODE_CPU_CORE_DEFINES_SVH
`define BYTECODE_CPU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BCC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BCC_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BCC_ASSERT(label, clk, rst, prop, msg)
`define BCC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/bcc_pkg.sv
// Package for the byte-coded core: payload types, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package bcc_pkg;
   localparam int MemBytesDefault = 65536;
   localparam int NumRegs = 8;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic [2:0]  register_select;
   } req_type;

   typedef struct packed {
      logic [31:0] program_counter;
      logic        halted_flag;
      logic        zero_flag;
      logic        carry_flag;
      logic [3:0]  status;
      logic [31:0] register_value;
   } rsp_type;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;

   localparam logic [7:0] OPC_NOP  = 8'h00;
   localparam logic [7:0] OPC_HALT = 8'hFF;
   localparam logic [7:0] OPC_LDI  = 8'h01;
   localparam logic [7:0] OPC_STR  = 8'h02;
   localparam logic [7:0] OPC_LDM  = 8'h03;
   localparam logic [7:0] OPC_ADD  = 8'h10;
   localparam logic [7:0] OPC_SUB  = 8'h11;
   localparam logic [7:0] OPC_CMP  = 8'h12;
   localparam logic [7:0] OPC_JMP  = 8'h20;
   localparam logic [7:0] OPC_JE   = 8'h21;
   localparam logic [7:0] OPC_JNE  = 8'h22;

   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_HALT    = 4'd1;
   localparam logic [3:0] ST_HALTED  = 4'd2;
   localparam logic [3:0] ST_PC_OOB  = 4'd3;
   localparam logic [3:0] ST_RD_OOB  = 4'd4;
   localparam logic [3:0] ST_WR_OOB  = 4'd5;
   localparam logic [3:0] ST_BAD_REG = 4'd6;
   localparam logic [3:0] ST_BAD_OPC = 4'd7;
   localparam logic [3:0] ST_LD_OOB  = 4'd8;

   // Operation select for the shared ALU.
   localparam logic [1:0] ALU_ADD = 2'd0;
   localparam logic [1:0] ALU_SUB = 2'd1;

   typedef struct packed {
      logic [31:0] sum;
      logic        carry;
      logic        zero;
   } alu_res_type;
endpackage

>>> rtl/core/bytecode_cpu_core.sv
// Top level of the byte-coded processor core.
// Depends on bcc_pkg and bcc_seq (which holds bcc_alu and bcc_mem).
//
//   channel | direction | payload           | handshake
//   req     | in        | bcc_pkg::req_type | req_valid / req_ready
//   rsp     | out       | bcc_pkg::rsp_type | rsp_valid / rsp_ready
//
// A step fetches its bytes through the single byte memory port, one instruction
// byte per cycle. After reset the memory is cleared one byte a cycle with
// req_ready low. A stalled result holds the core busy.
`timescale 1ns / 1ps
module bytecode_cpu_core #(
   parameter int MEM_BYTES = bcc_pkg::MemBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bcc_pkg::rsp_type rsp_data
);
   bcc_seq #(.MEM_BYTES(MEM_BYTES)) u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule

>>> rtl/core/bcc_alu.sv
// Shared 33-bit adder/subtractor used for register operations and program counter updates.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
module bcc_alu (
   input  logic [1:0]          alu_op,
   input  logic [31:0]         op_a,
   input  logic [31:0]         op_b,
   output bcc_pkg::alu_res_type res
);
   logic [32:0] wide;
   always_comb begin
      if (alu_op == bcc_pkg::ALU_SUB) begin
         wide = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         wide = {1'b0, op_a} + {1'b0, op_b};
      end
      res.sum = wide[31:0];
      res.carry = wide[32];
      res.zero = (wide[31:0] == 32'd0);
   end
endmodule

>>> rtl/core/bcc_mem.sv
// Byte memory with one port, registered read, and a clearing sweep after reset.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
`include "bytecode_cpu_core_defines.svh"
module bcc_mem #(
   parameter int MEM_BYTES = bcc_pkg::MemBytesDefault,
   localparam int AW = $clog2(MEM_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data,
   output logic          clr_done
);
   logic [7:0]  mem [MEM_BYTES];
   logic [AW:0] clr_ff, clr_in;
   logic [7:0]  rd_ff;

   assign clr_done = clr_ff[AW];
   assign clr_in = clr_done ? clr_ff : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!clr_done) begin
         mem[clr_ff[AW-1:0]] <= 8'd0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end
   assign rd_data = rd_ff;

   `BCC_ASSERT(a_no_write_in_clear, clock, reset, !clr_done |-> !wr_en, "write during clear")
   `BCC_ASSERT(a_clr_monotonic, clock, reset, clr_done |=> clr_done, "clear restarted")
   `BCC_ASSERT(a_clr_stable, clock, reset, clr_done |=> $stable(clr_ff), "clear counter moved")
endmodule

>>> rtl/core/bcc_seq.sv
// Sequencer: fetches instruction bytes one a cycle and runs the shared ALU.
// Depends on bcc_pkg, bcc_alu and bcc_mem.
`timescale 1ns / 1ps
`include "bytecode_cpu_core_defines.svh"
module bcc_seq #(
   parameter int MEM_BYTES = bcc_pkg::MemBytesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bcc_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [32:0] MEM_SZ = 33'(MEM_BYTES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_OPC   = 4'd1;  // opcode read issued
   localparam logic [3:0] S_FETCH = 4'd2;  // operand bytes
   localparam logic [3:0] S_DEC   = 4'd3;  // dispatch after operands
   localparam logic [3:0] S_LDRD  = 4'd4;  // data word read
   localparam logic [3:0] S_STWR  = 4'd5;  // data word write
   localparam logic [3:0] S_ALU   = 4'd6;
   localparam logic [3:0] S_RSP   = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [31:0] regs_ff [bcc_pkg::NumRegs];
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in, zf_ff, zf_in, cf_ff, cf_in;
   logic [3:0]  st_ff, st_in;
   logic [2:0]  sel_ff, sel_in;
   logic [7:0]  opc_ff, opc_in;
   logic [7:0]  b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  cnt_ff, cnt_in;     // bytes fetched or moved
   logic [2:0]  need_ff, need_in;   // bytes to fetch
   logic [32:0] ptr_ff, ptr_in;     // current memory byte address
   logic        reg_we;
   logic [2:0]  reg_wa;
   logic [31:0] reg_wd;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wd, mem_rd;
   logic          clr_done;
   logic          rd_pend_ff, rd_pend_in; // a read was issued last cycle
   logic          rd_oob_ff, rd_oob_in;

   logic [1:0]          alu_op;
   logic [31:0]         alu_a, alu_b;
   bcc_pkg::alu_res_type alu_res;

   bcc_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
      .clock(clock), .reset(reset), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wd), .rd_data(mem_rd), .clr_done(clr_done));

   bcc_alu u_alu (.alu_op(alu_op), .op_a(alu_a), .op_b(alu_b), .res(alu_res));

   logic [7:0] rbyte;
   assign rbyte = rd_oob_ff ? 8'd0 : mem_rd;
   assign req_ready = (state_ff == S_IDLE) && clr_done;
   assign rsp_valid = (state_ff == S_RSP);

   always_comb begin
      rsp_data.program_counter = pc_ff;
      rsp_data.halted_flag = halt_ff;
      rsp_data.zero_flag = zf_ff;
      rsp_data.carry_flag = cf_ff;
      rsp_data.status = st_ff;
      rsp_data.register_value = regs_ff[sel_ff];
   end

   function automatic logic bad3(input logic [7:0] x);
      bad3 = (x[7:3] != 5'd0);
   endfunction

   always_comb begin
      state_in = state_ff; pc_in = pc_ff; halt_in = halt_ff; zf_in = zf_ff;
      cf_in = cf_ff; st_in = st_ff; sel_in = sel_ff; opc_in = opc_ff;
      b1_in = b1_ff; b2_in = b2_ff; b3_in = b3_ff; word_in = word_ff;
      cnt_in = cnt_ff; need_in = need_ff; ptr_in = ptr_ff;
      rd_pend_in = 1'b0; rd_oob_in = 1'b0;
      reg_we = 1'b0; reg_wa = 3'd0; reg_wd = 32'd0;
      mem_we = 1'b0; mem_addr = ptr_ff[AW-1:0]; mem_wd = 8'd0;
      alu_op = bcc_pkg::ALU_ADD; alu_a = ptr_ff[31:0]; alu_b = 32'd1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               sel_in = req_data.register_select;
               st_in = bcc_pkg::ST_OK;
               state_in = S_RSP;
               unique case (req_data.operation)
                  bcc_pkg::OP_WRITE: begin
                     if ({17'd0, req_data.address} >= MEM_SZ) begin
                        st_in = bcc_pkg::ST_LD_OOB;
                     end else begin
                        mem_we = 1'b1;
                        mem_addr = AW'(req_data.address);
                        mem_wd = req_data.data_byte;
                     end
                  end
                  bcc_pkg::OP_START: begin
                     if ({17'd0, req_data.address} > MEM_SZ) begin
                        st_in = bcc_pkg::ST_LD_OOB;
                     end else begin
                        pc_in = {16'd0, req_data.address};
                        halt_in = 1'b0; zf_in = 1'b0; cf_in = 1'b0;
                     end
                  end
                  bcc_pkg::OP_STEP: begin
                     if (halt_ff) begin
                        st_in = bcc_pkg::ST_HALTED;
                     end else if ({1'b0, pc_ff} >= MEM_SZ) begin
                        halt_in = 1'b1;
                        st_in = bcc_pkg::ST_PC_OOB;
                     end else begin
                        mem_addr = pc_ff[AW-1:0];
                        ptr_in = {1'b0, pc_ff};
                        rd_pend_in = 1'b1;
                        state_in = S_OPC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_OPC: begin
            opc_in = mem_rd;
            cnt_in = 3'd0;
            unique case (mem_rd)
               bcc_pkg::OPC_LDI, bcc_pkg::OPC_STR, bcc_pkg::OPC_LDM: need_in = 3'd5;
               bcc_pkg::OPC_ADD, bcc_pkg::OPC_SUB: need_in = 3'd3;
               bcc_pkg::OPC_CMP: need_in = 3'd2;
               bcc_pkg::OPC_JMP, bcc_pkg::OPC_JE, bcc_pkg::OPC_JNE: need_in = 3'd4;
               default: need_in = 3'd0;
            endcase
            unique case (mem_rd)
               bcc_pkg::OPC_NOP: begin
                  alu_a = pc_ff;
                  pc_in = alu_res.sum;
                  state_in = S_RSP;
               end
               bcc_pkg::OPC_HALT: begin
                  halt_in = 1'b1; st_in = bcc_pkg::ST_HALT; state_in = S_RSP;
               end
               bcc_pkg::OPC_LDI, bcc_pkg::OPC_STR, bcc_pkg::OPC_LDM,
               bcc_pkg::OPC_ADD, bcc_pkg::OPC_SUB, bcc_pkg::OPC_CMP,
               bcc_pkg::OPC_JMP, bcc_pkg::OPC_JE, bcc_pkg::OPC_JNE: begin
                  // Issue read of the first operand byte at pc + 1.
                  alu_a = ptr_ff[31:0];
                  ptr_in = {1'b0, ptr_ff[31:0]} + 33'd1;
                  mem_addr = ptr_in[AW-1:0];
                  rd_oob_in = (ptr_in >= MEM_SZ);
                  rd_pend_in = 1'b1;
                  state_in = S_FETCH;
               end
               default: begin
                  halt_in = 1'b1; st_in = bcc_pkg::ST_BAD_OPC; state_in = S_RSP;
               end
            endcase
         end
         S_FETCH: begin
            // Operand bytes go into b1..b3 in order and shift into the word register.
            if (cnt_ff == 3'd0) begin
               b1_in = rbyte;
            end else if (cnt_ff == 3'd1) begin
               b2_in = rbyte;
            end else if (cnt_ff == 3'd2) begin
               b3_in = rbyte;
            end
            word_in = {rbyte, word_ff[31:8]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_in == need_ff) begin
               state_in = S_DEC;
            end else begin
               ptr_in = ptr_ff + 33'd1;
               mem_addr = ptr_in[AW-1:0];
               rd_oob_in = (ptr_in >= MEM_SZ);
               rd_pend_in = 1'b1;
            end
         end
         S_DEC: begin
            state_in = S_RSP;
            unique case (opc_ff)
               bcc_pkg::OPC_LDI, bcc_pkg::OPC_STR, bcc_pkg::OPC_LDM: begin
                  alu_op = bcc_pkg::ALU_ADD;
                  alu_a = pc_ff; alu_b = 32'd6;
                  if ({1'b0, pc_ff} + 33'd5 >= MEM_SZ) begin
                     halt_in = 1'b1; st_in = bcc_pkg::ST_RD_OOB;
                  end else if (bad3(b1_ff)) begin
                     halt_in = 1'b1; st_in = bcc_pkg::ST_BAD_REG;
                  end else if (opc_ff == bcc_pkg::OPC_LDI) begin
                     reg_we = 1'b1; reg_wa = b1_ff[2:0]; reg_wd = word_ff;
                     pc_in = alu_res.sum;
                  end else if ({1'b0, word_ff} + 33'd3 >= MEM_SZ) begin
                     halt_in = 1'b1;
                     st_in = (opc_ff == bcc_pkg::OPC_STR) ? bcc_pkg::ST_WR_OOB
                                                          : bcc_pkg::ST_RD_OOB;
                  end else begin
                     ptr_in = {1'b0, word_ff};
                     cnt_in = 3'd0;
                     b3_in = 8'd0;
                     if (opc_ff == bcc_pkg::OPC_STR) begin
                        state_in = S_STWR;
                     end else begin
                        mem_addr = word_ff[AW-1:0];
                        rd_pend_in = 1'b1;
                        state_in = S_LDRD;
                     end
                  end
               end
               bcc_pkg::OPC_ADD, bcc_pkg::OPC_SUB, bcc_pkg::OPC_CMP: begin
                  if ((opc_ff != bcc_pkg::OPC_CMP && bad3(b3_ff)) || bad3(b1_ff)
                      || bad3(b2_ff)) begin
                     halt_in = 1'b1; st_in = bcc_pkg::ST_BAD_REG;
                  end else begin
                     state_in = S_ALU;
                  end
               end
               default: begin
                  // Jumps.
                  alu_a = pc_ff; alu_b = 32'd5;
                  if ({1'b0, pc_ff} + 33'd4 >= MEM_SZ) begin
                     halt_in = 1'b1; st_in = bcc_pkg::ST_RD_OOB;
                  end else if (opc_ff == bcc_pkg::OPC_JMP
                               || (opc_ff == bcc_pkg::OPC_JE && zf_ff)
                               || (opc_ff == bcc_pkg::OPC_JNE && !zf_ff)) begin
                     pc_in = word_ff;
                  end else begin
                     pc_in = alu_res.sum;
                  end
               end
            endcase
         end
         S_LDRD: begin
            word_in = {mem_rd, word_ff[31:8]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_in == 3'd4) begin
               reg_we = 1'b1; reg_wa = b1_ff[2:0]; reg_wd = word_in;
               alu_a = pc_ff; alu_b = 32'd6;
               pc_in = alu_res.sum;
               state_in = S_RSP;
            end else begin
               ptr_in = ptr_ff + 33'd1;
               mem_addr = ptr_in[AW-1:0];
               rd_pend_in = 1'b1;
            end
         end
         S_STWR: begin
            mem_we = 1'b1;
            mem_addr = ptr_ff[AW-1:0];
            mem_wd = regs_ff[b1_ff[2:0]][8*cnt_ff[1:0] +: 8];
            cnt_in = cnt_ff + 3'd1;
            ptr_in = ptr_ff + 33'd1;
            if (cnt_in == 3'd4) begin
               alu_a = pc_ff; alu_b = 32'd6;
               pc_in = alu_res.sum;
               state_in = S_RSP;
            end
         end
         S_ALU: begin
            if (opc_ff == bcc_pkg::OPC_CMP) begin
               alu_op = bcc_pkg::ALU_SUB;
               alu_a = regs_ff[b1_ff[2:0]]; alu_b = regs_ff[b2_ff[2:0]];
               zf_in = alu_res.zero; cf_in = alu_res.carry;
               pc_in = pc_ff + 32'd3;
            end else begin
               alu_op = (opc_ff == bcc_pkg::OPC_SUB) ? bcc_pkg::ALU_SUB
                                                     : bcc_pkg::ALU_ADD;
               alu_a = regs_ff[b2_ff[2:0]]; alu_b = regs_ff[b3_ff[2:0]];
               zf_in = alu_res.zero; cf_in = alu_res.carry;
               reg_we = 1'b1; reg_wa = b1_ff[2:0]; reg_wd = alu_res.sum;
               pc_in = pc_ff + 32'd4;
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= 32'd0;
         halt_ff <= 1'b1;
         zf_ff <= 1'b0;
         cf_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < bcc_pkg::NumRegs; i++) begin
            regs_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         halt_ff <= halt_in;
         zf_ff <= zf_in;
         cf_ff <= cf_in;
         rd_pend_ff <= rd_pend_in;
         if (reg_we) begin
            regs_ff[reg_wa] <= reg_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in; sel_ff <= sel_in; opc_ff <= opc_in;
      b1_ff <= b1_in; b2_ff <= b2_in; b3_ff <= b3_in; word_ff <= word_in;
      cnt_ff <= cnt_in; need_ff <= need_in; ptr_ff <= ptr_in; rd_oob_ff <= rd_oob_in;
   end

   `BCC_ASSERT(a_rsp_halt, clock, reset,
      rsp_valid && (rsp_data.status != bcc_pkg::ST_OK) |-> rsp_data.halted_flag,
      "error without halt")
   `BCC_ASSERT(a_opc_after_read, clock, reset,
      (state_ff == S_OPC) |-> rd_pend_ff, "opcode without read")
   `BCC_ASSERT(a_busy_not_ready, clock, reset,
      (state_ff != S_IDLE) |-> !req_ready, "ready while busy")
endmodule

>>> bench/tb.sv
// Testbench for bytecode_cpu_core: drives write, start, step and noise items, predicts
// each result with a behavioral model of the core and compares the whole result.
// Depends on bcc_pkg and the bytecode_cpu_core RTL.
`timescale 1ns / 1ps
module tb;
   import bcc_pkg::*;

   localparam int MemBytes = MemBytesDefault;
   localparam int NumItems = 650;

   typedef struct packed {
      logic       check_fixed;
      req_type    item;
      logic [3:0] fixed_status;
      logic [31:0] fixed_pc;
   } table_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Shadow of the core state.
   logic [7:0]  core_mem [MemBytes];
   logic [31:0] core_regs [NumRegs];
   logic [31:0] core_pc;
   logic        core_halt;
   logic        core_zero;
   logic        core_carry;

   rsp_type     expected_rsps [$];
   logic        fixed_check [$];
   logic [3:0]  fixed_status_q [$];
   logic [31:0] fixed_pc_q [$];
   int          mismatches;
   bit          stall_long;
   bit          sending_done;

   bytecode_cpu_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] fetch_byte(logic [32:0] a);
      if (a >= MemBytes) return 8'h00;
      return core_mem[a];
   endfunction

   function automatic logic [31:0] fetch_word(logic [32:0] a, ref logic [3:0] st);
      if (a + 3 >= MemBytes) begin
         st = ST_RD_OOB;
         return 32'h0;
      end
      return {core_mem[a + 3], core_mem[a + 2], core_mem[a + 1], core_mem[a]};
   endfunction

   // Executes one instruction on the shadow state and returns its status.
   function automatic logic [3:0] run_instruction();
      logic [32:0] cur;
      logic [31:0] next_pc;
      logic [31:0] w;
      logic [31:0] v1;
      logic [31:0] v2;
      logic [32:0] total;
      logic [7:0]  opc;
      logic [7:0]  rd;
      logic [7:0]  ra;
      logic [7:0]  rb;
      logic [3:0]  st;
      st = ST_OK;
      if (core_halt) return ST_HALTED;
      if (core_pc >= MemBytes) begin
         core_halt = 1'b1;
         return ST_PC_OOB;
      end
      cur = {1'b0, core_pc};
      opc = core_mem[cur];
      next_pc = 32'(cur + 1);
      case (opc)
         OPC_NOP: ;
         OPC_HALT: begin
            core_halt = 1'b1;
            return ST_HALT;
         end
         OPC_LDI, OPC_STR, OPC_LDM: begin
            rd = fetch_byte(cur + 1);
            w = fetch_word(cur + 2, st);
            if (st == ST_OK && rd >= NumRegs) st = ST_BAD_REG;
            if (st == ST_OK) begin
               if (opc == OPC_LDI) begin
                  core_regs[rd] = w;
               end else if (opc == OPC_STR) begin
                  if ({1'b0, w} + 3 >= MemBytes) begin
                     st = ST_WR_OOB;
                  end else begin
                     v1 = core_regs[rd];
                     core_mem[w] = v1[7:0];
                     core_mem[w + 1] = v1[15:8];
                     core_mem[w + 2] = v1[23:16];
                     core_mem[w + 3] = v1[31:24];
                  end
               end else begin
                  v1 = fetch_word({1'b0, w}, st);
                  if (st == ST_OK) core_regs[rd] = v1;
               end
               next_pc = 32'(cur + 6);
            end
         end
         OPC_ADD, OPC_SUB: begin
            rd = fetch_byte(cur + 1);
            ra = fetch_byte(cur + 2);
            rb = fetch_byte(cur + 3);
            if (rd >= NumRegs || ra >= NumRegs || rb >= NumRegs) begin
               st = ST_BAD_REG;
            end else begin
               v1 = core_regs[ra];
               v2 = core_regs[rb];
               if (opc == OPC_ADD) begin
                  total = {1'b0, v1} + {1'b0, v2};
                  core_carry = total[32];
               end else begin
                  total = {1'b0, v1} - {1'b0, v2};
                  core_carry = v1 < v2;
               end
               core_regs[rd] = total[31:0];
               core_zero = total[31:0] == 32'h0;
               next_pc = 32'(cur + 4);
            end
         end
         OPC_CMP: begin
            ra = fetch_byte(cur + 1);
            rb = fetch_byte(cur + 2);
            if (ra >= NumRegs || rb >= NumRegs) begin
               st = ST_BAD_REG;
            end else begin
               core_zero = core_regs[ra] == core_regs[rb];
               core_carry = core_regs[ra] < core_regs[rb];
               next_pc = 32'(cur + 3);
            end
         end
         OPC_JMP, OPC_JE, OPC_JNE: begin
            w = fetch_word(cur + 1, st);
            if (st == ST_OK) begin
               if (opc == OPC_JMP || (opc == OPC_JE && core_zero) ||
                   (opc == OPC_JNE && !core_zero))
                  next_pc = w;
               else
                  next_pc = 32'(cur + 5);
            end
         end
         default: st = ST_BAD_OPC;
      endcase
      if (st != ST_OK) begin
         core_halt = 1'b1;
         return st;
      end
      core_pc = next_pc;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_core(req_type it);
      rsp_type r;
      logic [3:0] st;
      st = ST_OK;
      case (it.operation)
         OP_WRITE: begin
            if (it.address >= MemBytes) st = ST_LD_OOB;
            else core_mem[it.address] = it.data_byte;
         end
         OP_START: begin
            if (it.address > MemBytes) begin
               st = ST_LD_OOB;
            end else begin
               core_pc = {16'h0, it.address};
               core_halt = 1'b0;
               core_zero = 1'b0;
               core_carry = 1'b0;
            end
         end
         OP_STEP: st = run_instruction();
         default: ;
      endcase
      r.program_counter = core_pc;
      r.halted_flag = core_halt;
      r.zero_flag = core_zero;
      r.carry_flag = core_carry;
      r.status = st;
      r.register_value = core_regs[it.register_select];
      return r;
   endfunction

   task automatic send_item(req_type it, logic fixed, logic [3:0] fst, logic [31:0] fpc);
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_core(it));
      fixed_check.push_back(fixed);
      fixed_status_q.push_back(fst);
      fixed_pc_q.push_back(fpc);
   endtask

   task automatic send_gap();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type make_item(logic [1:0] op, logic [15:0] a, logic [7:0] d,
                                         logic [2:0] sel);
      req_type it;
      it.operation = op;
      it.address = a;
      it.data_byte = d;
      it.register_select = sel;
      return it;
   endfunction

   // Writes a short program of random instructions at base, then starts it.
   task automatic send_program(logic [15:0] base, int n_insts);
      logic [7:0] bytes [$];
      logic [7:0] opc;
      logic [31:0] w;
      int k;
      for (k = 0; k < n_insts; k++) begin
         case ($urandom_range(0, 11))
            0: opc = OPC_NOP;
            1: opc = OPC_LDI;
            2: opc = OPC_STR;
            3: opc = OPC_LDM;
            4, 5: opc = OPC_ADD;
            6: opc = OPC_SUB;
            7: opc = OPC_CMP;
            8: opc = OPC_JE;
            9: opc = OPC_JNE;
            10: opc = OPC_JMP;
            default: opc = $urandom_range(0, 15) == 0 ? OPC_HALT : 8'($urandom);
         endcase
         bytes.push_back(opc);
         // Mostly valid register indexes, now and then a bad one.
         repeat (3)
            bytes.push_back($urandom_range(0, 19) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)));
         // Addresses in low memory, near the program or near the end, sometimes out of range.
         case ($urandom_range(0, 5))
            0: w = $urandom;
            1: w = MemBytes - $urandom_range(1, 6);
            2: w = base + $urandom_range(0, 4 * n_insts);
            default: w = $urandom_range(0, 255);
         endcase
         if (opc == OPC_LDI && $urandom_range(0, 1)) w = $urandom;
         if (opc inside {OPC_LDI, OPC_STR, OPC_LDM}) begin
            bytes[bytes.size() - 2] = w[7:0];
            bytes[bytes.size() - 1] = w[15:8];
            bytes.push_back(w[23:16]);
            bytes.push_back(w[31:24]);
         end else if (opc inside {OPC_JMP, OPC_JE, OPC_JNE}) begin
            bytes[bytes.size() - 3] = w[7:0];
            bytes[bytes.size() - 2] = w[15:8];
            bytes[bytes.size() - 1] = w[23:16];
            bytes.push_back(w[31:24]);
         end
      end
      foreach (bytes[k]) begin
         send_item(make_item(OP_WRITE, 16'(base + k), bytes[k], 3'($urandom)),
                   1'b0, ST_OK, 0);
         send_gap();
      end
      send_item(make_item(OP_START, base, 8'($urandom), 3'($urandom)), 1'b0, ST_OK, 0);
   endtask

   table_row_type directed [] = '{
      // Step right after reset: the core is halted.
      '{1'b1, '{OP_STEP, 16'h0000, 8'h00, 3'd0}, ST_HALTED, 32'h0},
      '{1'b1, '{OP_START, 16'hFFFF, 8'hFF, 3'd7}, ST_OK, 32'hFFFF},
      // Opcode fetch at the last byte with operand bytes off the end.
      '{1'b0, '{OP_WRITE, 16'hFFFF, 8'h20, 3'd0}, ST_OK, 32'h0},
      '{1'b1, '{OP_STEP, 16'h0000, 8'h00, 3'd1}, ST_RD_OOB, 32'hFFFF},
      '{1'b0, '{OP_WRITE, 16'hFFFF, 8'h12, 3'd0}, ST_OK, 32'h0},
      '{1'b1, '{OP_START, 16'hFFFF, 8'h00, 3'd0}, ST_OK, 32'hFFFF},
      '{1'b0, '{OP_STEP, 16'h0000, 8'h00, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0000, 8'h01, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0001, 8'h03, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0002, 8'hFF, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0005, 8'hFF, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0006, 8'h10, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0007, 8'h04, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0008, 8'h03, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h0009, 8'h03, 3'd0}, ST_OK, 32'h0},
      '{1'b0, '{OP_WRITE, 16'h000A, 8'h99, 3'd0}, ST_OK, 32'h0},
      '{1'b1, '{OP_START, 16'h0000, 8'h00, 3'd3}, ST_OK, 32'h0},
      '{1'b0, '{OP_STEP, 16'h0000, 8'h00, 3'd3}, ST_OK, 32'h0},
      '{1'b0, '{OP_STEP, 16'h0000, 8'h00, 3'd4}, ST_OK, 32'h0},
      '{1'b1, '{OP_STEP, 16'h0000, 8'h00, 3'd4}, ST_BAD_OPC, 32'hA},
      // Unused operation code: no effect.
      '{1'b0, '{2'd3, 16'hFFFF, 8'hFF, 3'd7}, ST_OK, 32'h0},
      '{1'b1, '{OP_STEP, 16'h0000, 8'h00, 3'd0}, ST_HALTED, 32'hA}
   };

   initial begin
      int k;
      int base;
      int budget;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      sending_done = 1'b0;
      for (k = 0; k < MemBytes; k++) core_mem[k] = 8'h00;
      for (k = 0; k < NumRegs; k++) core_regs[k] = 32'h0;
      core_pc = 32'h0;
      core_halt = 1'b1;
      core_zero = 1'b0;
      core_carry = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[k])
         send_item(directed[k].item, directed[k].check_fixed, directed[k].fixed_status,
                   directed[k].fixed_pc);
      budget = NumItems;
      while (budget > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            // Noise item of any shape.
            send_item(req_type'($urandom), 1'b0, ST_OK, 0);
            budget--;
         end else begin
            base = $urandom_range(0, 7) == 0 ? MemBytes - 24 : $urandom_range(0, 200);
            k = $urandom_range(2, 5);
            send_program(16'(base), k);
            repeat ($urandom_range(3, 12)) begin
               send_item(make_item(OP_STEP, 16'($urandom), 8'($urandom), 3'($urandom)),
                         1'b0, ST_OK, 0);
               send_gap();
               budget--;
            end
            budget -= 4 * k;
         end
         send_gap();
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: a random stall pattern plus one long hold-off.
   initial begin
      int cycle_count;
      rsp_ready <= 1'b0;
      cycle_count = 0;
      stall_long = 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count == 68000) stall_long = 1'b1;
         if (cycle_count == 68300) stall_long = 1'b0;
         if (stall_long) rsp_ready <= 1'b0;
         else if (cycle_count % 400 < 150) rsp_ready <= 1'b1;
         else rsp_ready <= $urandom_range(0, 3) != 0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      logic fixed;
      logic [3:0] fst;
      logic [31:0] fpc;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            fixed = fixed_check.pop_front();
            fst = fixed_status_q.pop_front();
            fpc = fixed_pc_q.pop_front();
            if (fixed && (rsp_data.status !== fst || rsp_data.program_counter !== fpc)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d pc %h, got status %0d pc %h",
                           fst, fpc, rsp_data.status, rsp_data.program_counter);
            end
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      wait (sending_done);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bcc_pkg.sv
rtl/core/bcc_alu.sv
rtl/core/bcc_mem.sv
rtl/core/bcc_seq.sv
rtl/core/bytecode_cpu_core.sv
bench/tb.sv
